@@ hw/rtl/txq_pkg.sv @@
package txq_pkg;

    // request codes
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MARK    = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_EXPIRED = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_PACKETS  = 2'd0;
    localparam logic [1:0] CFG_ALMOST_FULL  = 2'd1;
    localparam logic [1:0] CFG_ALMOST_EMPTY = 2'd2;

    localparam int CFG_BITS  = 7;
    localparam int CFG_IDX_BITS = 2;
    localparam int FILL_BITS = 7;
    localparam int DROP_BITS = 32;
    localparam int PORT_HANDLE_BITS = 32;
    localparam int TIME_BITS = 64;

    localparam logic [CFG_BITS-1:0] MAX_PACKETS_RST  = 7'd64;
    localparam logic [CFG_BITS-1:0] ALMOST_FULL_RST  = 7'd48;
    localparam logic [CFG_BITS-1:0] ALMOST_EMPTY_RST = 7'd8;

    // one request after the control stage, waiting for ram read data
    typedef struct packed {
        logic                  pop_read;
        logic [2:0]            status;
        logic [FILL_BITS-1:0]  fill;
        logic [DROP_BITS-1:0]  drops;
        logic [TIME_BITS-1:0]  cur_time;
    } issue_t;

endpackage

@@ hw/rtl/txq_if.sv @@
interface txq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] pkt_handle;
    logic [63:0] expiry_time;
    logic [63:0] current_time;

    modport source (output valid, req_type, pkt_handle, expiry_time, current_time,
                    input ready);
    modport sink (input valid, req_type, pkt_handle, expiry_time, current_time,
                  output ready);
endinterface

interface txq_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] out_handle;
    logic [6:0]  fill_count;
    logic [31:0] full_drops;

    modport source (output valid, status, out_handle, fill_count, full_drops,
                    input ready);
    modport sink (input valid, status, out_handle, fill_count, full_drops,
                  output ready);
endinterface

@@ hw/rtl/txq_ram.sv @@
module txq_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/txq_ctrl.sv @@
module txq_ctrl #(
    parameter int QUEUE_DEPTH = 64,
    parameter int HW = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [txq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [txq_pkg::CFG_BITS-1:0]         cfg_wdata,
    input  logic                                 acc,
    input  logic [1:0]                           req_type,
    input  logic [txq_pkg::PORT_HANDLE_BITS-1:0] pkt_handle,
    input  logic [txq_pkg::TIME_BITS-1:0]        expiry_time,
    input  logic [txq_pkg::TIME_BITS-1:0]        current_time,
    output logic                                 wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]       wr_addr,
    output logic [HW+txq_pkg::TIME_BITS-1:0]     wr_data,
    output logic                                 rd_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]       rd_addr,
    output txq_pkg::issue_t                      issue
);

    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (CW > txq_pkg::CFG_BITS) ? CW : txq_pkg::CFG_BITS;
    localparam logic [AW-1:0]   LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [CMPW-1:0] DEPTH_X   = CMPW'(QUEUE_DEPTH);

    logic [AW-1:0]                  head_reg, head_next;
    logic [AW-1:0]                  tail_reg, tail_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [txq_pkg::DROP_BITS-1:0]  drops_reg, drops_next;
    logic [txq_pkg::CFG_BITS-1:0]   max_reg, afull_reg, aempty_reg;

    logic [CMPW-1:0] cnt_x, cnt_inc, cnt_dec, limit, cnt_new;
    logic [2:0]      status;
    logic            pop_read;

    always_comb
    begin
        cnt_x   = CMPW'(count_reg);
        cnt_inc = cnt_x + CMPW'(1);
        cnt_dec = cnt_x - CMPW'(1);
        limit   = (CMPW'(max_reg) > DEPTH_X) ? DEPTH_X : CMPW'(max_reg);

        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        drops_next = drops_reg;
        status     = txq_pkg::ST_OK;
        pop_read   = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;

        case (req_type)
            txq_pkg::REQ_PUSH:
            begin
                if (cnt_x >= limit)
                begin
                    drops_next = drops_reg + 1'b1;
                    status     = txq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = acc;
                    tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                    count_next = CW'(cnt_inc);
                    status     = (cnt_inc >= CMPW'(afull_reg)) ? txq_pkg::ST_MARK
                                                               : txq_pkg::ST_OK;
                end
            end
            txq_pkg::REQ_POP:
            begin
                if (cnt_x == '0)
                begin
                    status = txq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en      = acc;
                    pop_read   = 1'b1;
                    head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                    count_next = CW'(cnt_dec);
                    status     = (cnt_dec <= CMPW'(aempty_reg)) ? txq_pkg::ST_MARK
                                                                : txq_pkg::ST_OK;
                end
            end
            txq_pkg::REQ_FLUSH:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default:
            begin
                status = txq_pkg::ST_OK;
            end
        endcase

        cnt_new        = CMPW'(count_next);
        issue.pop_read = pop_read;
        issue.status   = status;
        issue.fill     = cnt_new[txq_pkg::FILL_BITS-1:0];
        issue.drops    = drops_next;
        issue.cur_time = current_time;
    end

    assign wr_addr = tail_reg;
    assign wr_data = {expiry_time, pkt_handle[HW-1:0]};
    assign rd_addr = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            drops_reg  <= '0;
            max_reg    <= txq_pkg::MAX_PACKETS_RST;
            afull_reg  <= txq_pkg::ALMOST_FULL_RST;
            aempty_reg <= txq_pkg::ALMOST_EMPTY_RST;
        end
        else
        begin
            if (acc)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                drops_reg <= drops_next;
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    txq_pkg::CFG_MAX_PACKETS:  max_reg    <= cfg_wdata;
                    txq_pkg::CFG_ALMOST_FULL:  afull_reg  <= cfg_wdata;
                    txq_pkg::CFG_ALMOST_EMPTY: aempty_reg <= cfg_wdata;
                    default:                   max_reg    <= max_reg;
                endcase
            end
        end
    end

endmodule

@@ hw/rtl/tx_queue_watermark_expiry_core.sv @@
// channel  | dir | handshake     | payload
// ---------+-----+---------------+-------------------------------------------------
// req      | in  | valid / ready | req_type, pkt_handle, expiry_time, current_time
// rsp      | out | valid / ready | status, out_handle, fill_count, full_drops
// cfg      | in  | cfg_wr_en     | cfg_index, cfg_wdata (no handshake back)
//
// one request beat per cycle while rsp drains; each result is staged, then held
// in the rsp beat (control stage, then ram read and expiry compare)
// a pop's entry comes from the single-port-read queue ram, read data registered
// req.ready drops only when the staged request cannot move into a held rsp beat
// reset clears pointers, count, drop counter, sets config defaults; ram is not cleared
module tx_queue_watermark_expiry_core #(
    parameter int QUEUE_DEPTH = 64,
    parameter int HANDLE_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [txq_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [txq_pkg::CFG_BITS-1:0]     cfg_wdata,
    txq_req_if.sink                          req,
    txq_rsp_if.source                        rsp
);

    // handles wider than the port never carry more than the port's bits
    localparam int HW = (HANDLE_BITS < txq_pkg::PORT_HANDLE_BITS)
                        ? HANDLE_BITS : txq_pkg::PORT_HANDLE_BITS;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int DW = HW + txq_pkg::TIME_BITS;

    // handshake
    logic acc;
    logic pend_move;

    // ram side
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [DW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [DW-1:0] ram_rd_data;

    // stage after control: waits on the ram read
    txq_pkg::issue_t issue;
    txq_pkg::issue_t pend_reg;
    logic            pend_valid_reg, pend_valid_next;

    // result beat held for the consumer
    logic                                  out_valid_reg, out_valid_next;
    logic [2:0]                            status_reg, status_next;
    logic [txq_pkg::PORT_HANDLE_BITS-1:0]  handle_reg, handle_next;
    logic [txq_pkg::FILL_BITS-1:0]         fill_reg;
    logic [txq_pkg::DROP_BITS-1:0]         drops_reg;

    logic [txq_pkg::TIME_BITS-1:0] rd_expiry;
    logic [HW-1:0]                 rd_handle;
    logic                          stale;

    // the staged request moves on when the result slot is free or being emptied
    assign pend_move = !out_valid_reg || rsp.ready;
    assign req.ready = !pend_valid_reg || pend_move;
    assign acc       = req.valid && req.ready;

    txq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HW          (HW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .acc          (acc),
        .req_type     (req.req_type),
        .pkt_handle   (req.pkt_handle),
        .expiry_time  (req.expiry_time),
        .current_time (req.current_time),
        .wr_en        (ram_wr_en),
        .wr_addr      (ram_wr_addr),
        .wr_data      (ram_wr_data),
        .rd_en        (ram_rd_en),
        .rd_addr      (ram_rd_addr),
        .issue        (issue)
    );

    // one entry per slot: expiry time above, handle below
    txq_ram #(
        .WIDTH (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // ram data holds while the staged pop waits, since no new read is issued
    assign rd_expiry = ram_rd_data[DW-1:HW];
    assign rd_handle = ram_rd_data[HW-1:0];
    assign stale     = (rd_expiry != '0) && (rd_expiry < pend_reg.cur_time);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (acc)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_move)
        begin
            pend_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (pend_valid_reg && pend_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        // expired entries are still handed back so the buffer can be freed
        if (pend_reg.pop_read)
        begin
            handle_next = txq_pkg::PORT_HANDLE_BITS'(rd_handle);
            status_next = stale ? txq_pkg::ST_EXPIRED : pend_reg.status;
        end
        else
        begin
            handle_next = '0;
            status_next = pend_reg.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            pend_reg <= issue;
        end
        if (pend_valid_reg && pend_move)
        begin
            status_reg <= status_next;
            handle_reg <= handle_next;
            fill_reg   <= pend_reg.fill;
            drops_reg  <= pend_reg.drops;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.out_handle = handle_reg;
    assign rsp.fill_count = fill_reg;
    assign rsp.full_drops = drops_reg;

    // read data must not change under a staged pop that is waiting
    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && pend_reg.pop_read && !pend_move |=> $stable(ram_rd_data))
        else $error("ram read data changed under a waiting pop");

    // only a pop that found an entry goes through the ram read
    a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && pend_reg.pop_read |->
            (pend_reg.status == txq_pkg::ST_OK || pend_reg.status == txq_pkg::ST_MARK))
        else $error("ram read staged for a request that found no entry");

    // rejected pushes and empty pops carry no handle
    a_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == txq_pkg::ST_FULL || rsp.status == txq_pkg::ST_EMPTY)
            |-> rsp.out_handle == '0)
        else $error("handle returned with a full or empty status");

    // a staged request always leaves when the result slot frees
    a_pend_drain: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && pend_move && !acc |=> !pend_valid_reg && out_valid_reg)
        else $error("staged request lost or stuck");

endmodule
